FILE: hdl/reaction_newton_implicit_step_core_macros.svh
// assertion macros shared by the rtl
`ifndef REACTION_NEWTON_IMPLICIT_STEP_CORE_MACROS_SVH
`define REACTION_NEWTON_IMPLICIT_STEP_CORE_MACROS_SVH
// implication checked at every rising edge outside reset
`define RN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define RN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: hdl/rnis_pkg.sv
// package: types, constants and fixed-point helpers for the reaction step core
`default_nettype none
package rnis_pkg;
	localparam int W = 32;
	localparam int F = 24;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE = W'(64'sd1 <<< F);

	localparam logic [2:0] REG_LAMBDA = 3'd0;
	localparam logic [2:0] REG_THETA  = 3'd1;
	localparam logic [2:0] REG_ALPHA  = 3'd2;
	localparam logic [2:0] REG_BETA   = 3'd3;
	localparam logic [2:0] REG_HSTEP  = 3'd4;
	localparam logic [2:0] REG_TOL    = 3'd5;
	localparam logic [2:0] REG_LIMIT  = 3'd6;
	localparam logic [2:0] REG_MODE   = 3'd7;

	typedef struct packed {
		logic signed [31:0] u_in;
		logic signed [31:0] v_in;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] u_out;
		logic signed [31:0] v_out;
		logic               status;
		logic [5:0]         iterations_used;
	} out_word_t;

	// micro-op of the shared unit
	typedef enum logic [2:0] {
		OP_MUL, OP_ADD, OP_SUB, OP_MOV, OP_DIV
	} op_t;

	// operand/destination slots of the register file
	typedef enum logic [4:0] {
		R_U0, R_V0, R_S0, R_S1, R_F0, R_F1, R_H, R_LAM, R_TH, R_ALP, R_BET, R_ONE,
		R_ZERO, R_T0, R_T1, R_T2, R_T3, R_T4, R_J00, R_J01, R_J10, R_J11, R_DET,
		R_N0, R_N1, R_UA, R_VA
	} slot_t;

	typedef struct packed {
		op_t   op;
		slot_t a;
		slot_t b;
		slot_t d;
	} uop_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RUN, ST_DIVW, ST_CHECK, ST_DONE
	} state_t;

	// program counter width
	localparam int PC_BITS = 7;

	function automatic uop_t mk(op_t o, slot_t a, slot_t b, slot_t d);
		uop_t r;
		r.op = o; r.a = a; r.b = b; r.d = d;
		return r;
	endfunction

	// rom of micro-ops
	function automatic uop_t prog(logic [PC_BITS-1:0] pc);
		uop_t r;
		r = mk(OP_MOV, R_ZERO, R_ZERO, R_ZERO);
		case (pc)
			// crank-nicolson explicit half step: react_u(u0,v0), react_v(u0,v0)
			7'd0:  r = mk(OP_SUB, R_ONE, R_U0, R_T0);
			7'd1:  r = mk(OP_MUL, R_U0, R_T0, R_T0);
			7'd2:  r = mk(OP_SUB, R_U0, R_TH, R_T1);
			7'd3:  r = mk(OP_MUL, R_T0, R_T1, R_T0);
			7'd4:  r = mk(OP_SUB, R_V0, R_T0, R_T0);
			7'd5:  r = mk(OP_MUL, R_LAM, R_T0, R_T0);
			7'd6:  r = mk(OP_MUL, R_H, R_T0, R_T0);
			7'd7:  r = mk(OP_ADD, R_U0, R_T0, R_UA);
			7'd8:  r = mk(OP_MUL, R_ALP, R_U0, R_T1);
			7'd9:  r = mk(OP_MUL, R_BET, R_V0, R_T2);
			7'd10: r = mk(OP_SUB, R_T1, R_T2, R_T1);
			7'd11: r = mk(OP_MUL, R_H, R_T1, R_T1);
			7'd12: r = mk(OP_ADD, R_V0, R_T1, R_V0);
			7'd13: r = mk(OP_MOV, R_UA, R_ZERO, R_U0);
			// explicit guess
			7'd14: r = mk(OP_SUB, R_ONE, R_U0, R_T0);
			7'd15: r = mk(OP_MUL, R_U0, R_T0, R_T0);
			7'd16: r = mk(OP_SUB, R_U0, R_TH, R_T1);
			7'd17: r = mk(OP_MUL, R_T0, R_T1, R_T0);
			7'd18: r = mk(OP_SUB, R_V0, R_T0, R_T0);
			7'd19: r = mk(OP_MUL, R_LAM, R_T0, R_T0);
			7'd20: r = mk(OP_MUL, R_H, R_T0, R_T0);
			7'd21: r = mk(OP_ADD, R_U0, R_T0, R_S0);
			7'd22: r = mk(OP_MUL, R_ALP, R_U0, R_T1);
			7'd23: r = mk(OP_MUL, R_BET, R_V0, R_T2);
			7'd24: r = mk(OP_SUB, R_T1, R_T2, R_T1);
			7'd25: r = mk(OP_MUL, R_H, R_T1, R_T1);
			7'd26: r = mk(OP_ADD, R_V0, R_T1, R_S1);
			// residual
			7'd27: r = mk(OP_SUB, R_ONE, R_S0, R_T0);
			7'd28: r = mk(OP_MUL, R_S0, R_T0, R_T0);
			7'd29: r = mk(OP_SUB, R_S0, R_TH, R_T1);
			7'd30: r = mk(OP_MUL, R_T0, R_T1, R_T0);
			7'd31: r = mk(OP_SUB, R_S1, R_T0, R_T0);
			7'd32: r = mk(OP_MUL, R_LAM, R_T0, R_T0);
			7'd33: r = mk(OP_MUL, R_H, R_T0, R_T0);
			7'd34: r = mk(OP_SUB, R_S0, R_T0, R_T0);
			7'd35: r = mk(OP_SUB, R_T0, R_U0, R_F0);
			7'd36: r = mk(OP_MUL, R_ALP, R_S0, R_T1);
			7'd37: r = mk(OP_MUL, R_BET, R_S1, R_T2);
			7'd38: r = mk(OP_SUB, R_T1, R_T2, R_T1);
			7'd39: r = mk(OP_MUL, R_H, R_T1, R_T1);
			7'd40: r = mk(OP_SUB, R_S1, R_T1, R_T1);
			7'd41: r = mk(OP_SUB, R_T1, R_V0, R_F1);
			// newton jacobian and numerators
			7'd42: r = mk(OP_ADD, R_S0, R_S0, R_T0);
			7'd43: r = mk(OP_SUB, R_T0, R_ONE, R_T0);
			7'd44: r = mk(OP_SUB, R_S0, R_TH, R_T1);
			7'd45: r = mk(OP_MUL, R_T0, R_T1, R_T0);
			7'd46: r = mk(OP_SUB, R_S0, R_ONE, R_T1);
			7'd47: r = mk(OP_MUL, R_S0, R_T1, R_T1);
			7'd48: r = mk(OP_ADD, R_T0, R_T1, R_T0);
			7'd49: r = mk(OP_MUL, R_LAM, R_T0, R_T0);
			7'd50: r = mk(OP_MUL, R_H, R_T0, R_T0);
			7'd51: r = mk(OP_SUB, R_ONE, R_T0, R_J00);
			7'd52: r = mk(OP_MUL, R_H, R_LAM, R_T0);
			7'd53: r = mk(OP_SUB, R_ZERO, R_T0, R_J01);
			7'd54: r = mk(OP_MUL, R_H, R_ALP, R_T0);
			7'd55: r = mk(OP_SUB, R_ZERO, R_T0, R_J10);
			7'd56: r = mk(OP_MUL, R_H, R_BET, R_T0);
			7'd57: r = mk(OP_ADD, R_ONE, R_T0, R_J11);
			7'd58: r = mk(OP_MUL, R_J00, R_J11, R_T0);
			7'd59: r = mk(OP_MUL, R_J01, R_J10, R_T1);
			7'd60: r = mk(OP_SUB, R_T0, R_T1, R_DET);
			7'd61: r = mk(OP_MUL, R_J11, R_F0, R_T0);
			7'd62: r = mk(OP_MUL, R_J01, R_F1, R_T1);
			7'd63: r = mk(OP_SUB, R_T0, R_T1, R_N0);
			7'd64: r = mk(OP_MUL, R_J00, R_F1, R_T0);
			7'd65: r = mk(OP_MUL, R_J10, R_F0, R_T1);
			7'd66: r = mk(OP_SUB, R_T0, R_T1, R_N1);
			// update (skipped when det is zero)
			7'd67: r = mk(OP_DIV, R_N0, R_DET, R_T3);
			7'd68: r = mk(OP_DIV, R_N1, R_DET, R_T4);
			7'd69: r = mk(OP_SUB, R_S0, R_T3, R_S0);
			7'd70: r = mk(OP_SUB, R_S1, R_T4, R_S1);
			default: r = mk(OP_MOV, R_ZERO, R_ZERO, R_ZERO);
		endcase
		return r;
	endfunction

	localparam logic [PC_BITS-1:0] PC_CN    = 7'd0;
	localparam logic [PC_BITS-1:0] PC_GUESS = 7'd14;
	localparam logic [PC_BITS-1:0] PC_RES   = 7'd27;
	localparam logic [PC_BITS-1:0] PC_RESE  = 7'd41;
	localparam logic [PC_BITS-1:0] PC_NEWT  = 7'd42;
	localparam logic [PC_BITS-1:0] PC_NUME  = 7'd66;
	localparam logic [PC_BITS-1:0] PC_UPDE  = 7'd70;

	function automatic logic signed [W-1:0] sat_add(logic signed [W-1:0] a,
	                                                 logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_sub(logic signed [W-1:0] a,
	                                                 logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] mag(logic signed [W-1:0] a);
		return a[W-1] ? W'(-a) : a;
	endfunction

	// rounded product magnitude to signed word
	function automatic logic signed [W-1:0] sat_mag(logic [2*W-1:0] m, logic neg);
		if (neg) begin
			if (m > {{W{1'b0}}, 1'b1, {(W-1){1'b0}}}) return WMIN;
			return W'(-m);
		end
		if (m > {{(W+1){1'b0}}, {(W-1){1'b1}}}) return WMAX;
		return m[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_abs(logic signed [W-1:0] a);
		if (a == WMIN) return WMAX;
		return a[W-1] ? -a : a;
	endfunction
endpackage
`default_nettype wire

FILE: hdl/reaction_newton_implicit_step_core.sv
// top level: implicit fitzhugh-nagumo reaction step, newton solve on one shared unit
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+----------------------------
//  in      | input     | in_valid/in_stall  | u_in, v_in
//  out     | output    | out_valid/out_stall| u_out, v_out, status, iters
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// one micro-op per cycle on a shared multiply/add unit; a divide holds the
// unit from issue through its quotient bits, one a cycle, to write-back
// per word: accept, the crank-nicolson half step in that mode, the guess and
// residual micro-ops, a check and done; a newton iteration adds the jacobian and
// numerators, two divides and update (skipped if det is zero) and the residual
// in_stall is high from acceptance until the result word is taken
// reset loads the register defaults and returns to idle with no result offered
`default_nettype none
`include "reaction_newton_implicit_step_core_macros.svh"
module reaction_newton_implicit_step_core (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  rnis_pkg::in_word_t        in_word,
	output logic                      out_valid,
	input  wire                       out_stall,
	output rnis_pkg::out_word_t       out_word,
	input  wire                       cfg_we,
	input  wire  [2:0]                cfg_index,
	input  wire  [31:0]               cfg_data
);
	import rnis_pkg::*;

	localparam int QB = W + F;          // quotient bits of a divide
	localparam int QC = $clog2(QB + 1);

	// configuration registers
	logic signed [31:0] lam_q, th_q, alp_q, bet_q;
	logic [30:0]        hstep_q;
	logic [15:0]        tol_q;
	logic [5:0]         limit_q;
	logic               mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_q <= '0; th_q <= '0; alp_q <= '0; bet_q <= '0;
			hstep_q <= '0; tol_q <= 16'd16; limit_q <= 6'd50; mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LAMBDA: lam_q   <= cfg_data;
				REG_THETA:  th_q    <= cfg_data;
				REG_ALPHA:  alp_q   <= cfg_data;
				REG_BETA:   bet_q   <= cfg_data;
				REG_HSTEP:  hstep_q <= cfg_data[30:0];
				REG_TOL:    tol_q   <= cfg_data[15:0];
				REG_LIMIT:  limit_q <= cfg_data[5:0];
				REG_MODE:   mode_q  <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// working register file, one word per slot
	logic signed [W-1:0] rf_q [27];

	state_t              state_q, state_d;
	logic [PC_BITS-1:0]  pc_q;
	logic [5:0]          iters_q;
	logic                status_q;
	uop_t                uop;
	logic signed [W-1:0] opa, opb, res_alu;
	logic [2*W-1:0]      prod;
	logic                wr_en;

	// divider state
	logic [QC-1:0]       dcnt_q;
	logic [QB-1:0]       dnum_q;   // shifting dividend
	logic [QB-1:0]       dquo_q;
	logic [W-1:0]        drem_q;
	logic [W-1:0]        dden_q;
	logic                dneg_q;
	logic [W:0]          rem_sh;
	logic                rem_ge;

	// residual
	logic signed [W-1:0] a0, a1, resv;
	logic                res_big;

	assign uop = prog(pc_q);
	assign opa = rf_q[uop.a];
	assign opb = rf_q[uop.b];
	assign prod = {{W{1'b0}}, mag(opa)} * {{W{1'b0}}, mag(opb)}
	            + ((2*W)'(1) << (F - 1));

	always_comb begin
		case (uop.op)
			OP_MUL:  res_alu = sat_mag(prod >> F, opa[W-1] ^ opb[W-1]);
			OP_ADD:  res_alu = sat_add(opa, opb);
			OP_SUB:  res_alu = sat_sub(opa, opb);
			OP_MOV:  res_alu = opa;
			default: res_alu = sat_mag({{W{1'b0}}, dquo_q[W-1:0]} |
			                   ((|dquo_q[QB-1:W]) ? {{(W-1){1'b0}}, 1'b1, {W{1'b0}}}
			                   : '0), dneg_q);
		endcase
	end

	assign rem_sh = {drem_q, dnum_q[QB-1]};
	assign rem_ge = rem_sh >= {1'b0, dden_q};

	assign a0 = sat_abs(rf_q[R_F0]);
	assign a1 = sat_abs(rf_q[R_F1]);
	assign resv = (a0 > a1) ? a0 : a1;
	assign res_big = resv > $signed({16'd0, tol_q});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_RUN;
			ST_RUN: begin
				// after an update or a singular jacobian the residual is rerun first
				if (uop.op == OP_DIV) state_d = ST_DIVW;
				else if (pc_q == PC_RESE) state_d = ST_CHECK;
			end
			ST_DIVW:  if (dcnt_q == '0) state_d = ST_RUN;
			ST_CHECK: state_d = ST_RUN;
			ST_DONE:  if (!out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
		if (state_q == ST_CHECK) begin
			if (!res_big || (iters_q != '0 && iters_q >= limit_q)) state_d = ST_DONE;
		end
	end

	// outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_DONE);
		out_word.u_out = rf_q[R_S0];
		out_word.v_out = rf_q[R_S1];
		out_word.status = status_q;
		out_word.iterations_used = iters_q;
		wr_en = (state_q == ST_RUN) && (uop.op != OP_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			iters_q <= '0;
			status_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: if (in_valid) begin
					pc_q <= mode_q ? PC_CN : PC_GUESS;
					iters_q <= '0;
					status_q <= 1'b0;
				end
				ST_RUN: begin
					if (uop.op == OP_DIV) dcnt_q <= QC'(QB);
					else if (pc_q == PC_NUME && rf_q[R_DET] == '0) pc_q <= PC_RES;
					else if (pc_q == PC_UPDE) pc_q <= PC_RES;
					else pc_q <= pc_q + 1'b1;
				end
				ST_DIVW: begin
					if (dcnt_q == '0) pc_q <= pc_q + 1'b1;
					else dcnt_q <= dcnt_q - 1'b1;
				end
				ST_CHECK: begin
					pc_q <= PC_NEWT;
				end
				default: ;
			endcase
			// iteration counted when the update is written or skipped for a zero determinant
			if (state_q == ST_RUN && pc_q == PC_UPDE) iters_q <= iters_q + 1'b1;
			if (state_q == ST_RUN && pc_q == PC_NUME && rf_q[R_DET] == '0)
				iters_q <= iters_q + 1'b1;
			if (state_q == ST_CHECK && iters_q != '0) status_q <= res_big;
		end
	end

	// register file and divider datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			rf_q[R_U0] <= in_word.u_in;
			rf_q[R_V0] <= in_word.v_in;
			rf_q[R_H] <= mode_q ? W'({1'b0, hstep_q} >> 1) : W'({1'b0, hstep_q});
			rf_q[R_LAM] <= lam_q; rf_q[R_TH] <= th_q;
			rf_q[R_ALP] <= alp_q; rf_q[R_BET] <= bet_q;
			rf_q[R_ONE] <= ONE; rf_q[R_ZERO] <= '0;
		end else if (wr_en) begin
			rf_q[uop.d] <= res_alu;
		end else if (state_q == ST_DIVW && dcnt_q == '0) begin
			rf_q[uop.d] <= res_alu;
		end
		if (state_q == ST_RUN && uop.op == OP_DIV) begin
			dnum_q <= QB'({{W{1'b0}}, mag(opa)} << F);
			dden_q <= mag(opb);
			dneg_q <= opa[W-1] ^ opb[W-1];
			drem_q <= '0;
			dquo_q <= '0;
		end else if (state_q == ST_DIVW && dcnt_q != '0) begin
			dnum_q <= dnum_q << 1;
			drem_q <= rem_ge ? W'(rem_sh - {1'b0, dden_q}) : rem_sh[W-1:0];
			dquo_q <= {dquo_q[QB-2:0], rem_ge};
		end
	end

	`RN_ASSERT_IMP(a_out_only_done, clk, arst_n, out_valid, in_stall, "result while idle")
	`RN_ASSERT_IMP(a_iter_limit, clk, arst_n, out_valid, iters_q <= 6'd63, "iteration overflow")
	`RN_ASSERT_NXT(a_hold_out, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_word), "result changed while stalled")
endmodule
`default_nettype wire

FILE: tb/tb_reaction_newton_implicit_step_core.sv
// testbench: implicit reaction step core checked word by word against a fixed-point predictor
`default_nettype none
module tb_reaction_newton_implicit_step_core;
	import rnis_pkg::*;

	localparam int WATCH_LIMIT = 60000;
	localparam int HOLD_CYCLES = 400;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_word;
	logic      cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_LAMBDA;
	logic [31:0] cfg_data = '0;

	reaction_newton_implicit_step_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// register copy used by the predictor
	logic signed [31:0] lam_r, th_r, alp_r, bet_r;
	logic [30:0] step_r;
	logic [15:0] tol_r;
	logic [5:0]  limit_r;
	logic        cn_r;

	in_word_t  pending_words[$];
	out_word_t awaited_q[$];
	int  fail_cnt = 0;
	int  taken_cnt = 0;
	int  idle_cyc = 0;
	bit  quiet = 1'b0;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  hold_cnt = 0;
	bit  hold_done = 1'b0;

	// ---------------- fixed-point arithmetic, saturating Q8.24 ----------------
	function automatic logic signed [31:0] clamp64(longint s);
		if (s > longint'(WMAX)) return WMAX;
		if (s < longint'(WMIN)) return WMIN;
		return s[31:0];
	endfunction

	function automatic logic signed [31:0] q_add(logic signed [31:0] a, logic signed [31:0] b);
		return clamp64(longint'(a) + longint'(b));
	endfunction

	function automatic logic signed [31:0] q_sub(logic signed [31:0] a, logic signed [31:0] b);
		return clamp64(longint'(a) - longint'(b));
	endfunction

	function automatic logic signed [31:0] q_abs(logic signed [31:0] a);
		return clamp64(a < 0 ? -longint'(a) : longint'(a));
	endfunction

	// signed magnitude back to a word, saturating
	function automatic logic signed [31:0] q_pack(logic [63:0] m, logic neg);
		if (neg) begin
			if (m > 64'h8000_0000) return WMIN;
			return 32'(-m);
		end
		if (m > 64'h7FFF_FFFF) return WMAX;
		return m[31:0];
	endfunction

	// product magnitude rounded half away from zero
	function automatic logic signed [31:0] q_mul(logic signed [31:0] a, logic signed [31:0] b);
		longint ma, mb;
		logic [63:0] p;
		ma = a < 0 ? -longint'(a) : longint'(a);
		mb = b < 0 ? -longint'(b) : longint'(b);
		p = (64'(ma) * 64'(mb) + 64'h80_0000) >> 24;
		return q_pack(p, a[31] ^ b[31]);
	endfunction

	// quotient truncated toward zero
	function automatic logic signed [31:0] q_div(logic signed [31:0] n, logic signed [31:0] d);
		longint mn, md;
		logic [63:0] q;
		mn = n < 0 ? -longint'(n) : longint'(n);
		md = d < 0 ? -longint'(d) : longint'(d);
		q = (64'(mn) << 24) / 64'(md);
		return q_pack(q, n[31] ^ d[31]);
	endfunction

	// lambda*(v - u(1-u)(u-theta))
	function automatic logic signed [31:0] rate_u(logic signed [31:0] u, logic signed [31:0] v);
		logic signed [31:0] cub;
		cub = q_mul(q_mul(u, q_sub(ONE, u)), q_sub(u, th_r));
		return q_mul(lam_r, q_sub(v, cub));
	endfunction

	function automatic logic signed [31:0] rate_u_slope(logic signed [31:0] u);
		logic signed [31:0] t1, t2;
		t1 = q_mul(q_sub(q_add(u, u), ONE), q_sub(u, th_r));
		t2 = q_mul(u, q_sub(u, ONE));
		return q_mul(lam_r, q_add(t1, t2));
	endfunction

	function automatic logic signed [31:0] rate_v(logic signed [31:0] u, logic signed [31:0] v);
		return q_sub(q_mul(alp_r, u), q_mul(bet_r, v));
	endfunction

	// implicit step of one grid point
	function automatic out_word_t step_predict(in_word_t w);
		logic signed [31:0] h, u0, v0, ua, va, s0, s1, f0, f1, res;
		logic signed [31:0] j00, j01, j10, j11, det, n0, n1;
		int iters;
		out_word_t r;
		h = 32'(step_r);
		u0 = w.u_in;
		v0 = w.v_in;
		iters = 0;
		r.status = 1'b0;
		if (cn_r) begin
			h = h >>> 1;
			ua = q_add(u0, q_mul(h, rate_u(u0, v0)));
			va = q_add(v0, q_mul(h, rate_v(u0, v0)));
			u0 = ua;
			v0 = va;
		end
		s0 = q_add(u0, q_mul(h, rate_u(u0, v0)));
		s1 = q_add(v0, q_mul(h, rate_v(u0, v0)));
		f0 = q_sub(q_sub(s0, q_mul(h, rate_u(s0, s1))), u0);
		f1 = q_sub(q_sub(s1, q_mul(h, rate_v(s0, s1))), v0);
		res = q_abs(f0) > q_abs(f1) ? q_abs(f0) : q_abs(f1);
		if (res > $signed({16'd0, tol_r})) begin
			do begin
				j00 = q_sub(ONE, q_mul(h, rate_u_slope(s0)));
				j01 = q_sub(0, q_mul(h, lam_r));
				j10 = q_sub(0, q_mul(h, alp_r));
				j11 = q_add(ONE, q_mul(h, bet_r));
				det = q_sub(q_mul(j00, j11), q_mul(j01, j10));
				// singular jacobian leaves the iterate unchanged
				if (det != 0) begin
					n0 = q_sub(q_mul(j11, f0), q_mul(j01, f1));
					n1 = q_sub(q_mul(j00, f1), q_mul(j10, f0));
					s0 = q_sub(s0, q_div(n0, det));
					s1 = q_sub(s1, q_div(n1, det));
				end
				f0 = q_sub(q_sub(s0, q_mul(h, rate_u(s0, s1))), u0);
				f1 = q_sub(q_sub(s1, q_mul(h, rate_v(s0, s1))), v0);
				res = q_abs(f0) > q_abs(f1) ? q_abs(f0) : q_abs(f1);
				iters++;
			end while (res > $signed({16'd0, tol_r}) && iters < limit_r);
			r.status = res > $signed({16'd0, tol_r});
		end
		r.u_out = s0;
		r.v_out = s1;
		r.iterations_used = 6'(iters);
		return r;
	endfunction

	// ---------------- clock and watchdog ----------------
	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cyc <= 0;
		end else if (idle_cyc >= WATCH_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cyc <= idle_cyc + 1;
		end
	end

	// ---------------- driver: feeds words from the pending queue ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
		end else begin
			// word taken at this edge: predict with the current register copy
			if (in_valid && !in_stall)
				awaited_q.push_back(step_predict(in_word));
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					in_word <= pending_words.pop_front();
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 17);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor and receiver stall ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_q.size() == 0) begin
					$display("%0t: result word with nothing awaited: u %h v %h st %b it %0d",
						$time, out_word.u_out, out_word.v_out, out_word.status,
						out_word.iterations_used);
					fail_cnt++;
				end else begin
					out_word_t e;
					e = awaited_q.pop_front();
					if (e.u_out !== out_word.u_out)
						$display("%0t: u_out expected %h actual %h", $time, e.u_out, out_word.u_out);
					if (e.v_out !== out_word.v_out)
						$display("%0t: v_out expected %h actual %h", $time, e.v_out, out_word.v_out);
					if (e.status !== out_word.status)
						$display("%0t: status expected %b actual %b", $time, e.status,
							out_word.status);
					if (e.iterations_used !== out_word.iterations_used)
						$display("%0t: iterations_used expected %0d actual %0d", $time,
							e.iterations_used, out_word.iterations_used);
					if (e !== out_word)
						fail_cnt++;
				end
				taken_cnt++;
			end
			// one long hold-off while the sender keeps offering
			if (!hold_done && taken_cnt == 100) begin
				hold_cnt = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(1, 17) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------- stimulus ----------------
	// block idle: nothing queued, nothing in flight
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_words.size() != 0 || in_valid || awaited_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// write enable stays high across back-to-back writes
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		case (idx)
			REG_LAMBDA: lam_r = d;
			REG_THETA:  th_r = d;
			REG_ALPHA:  alp_r = d;
			REG_BETA:   bet_r = d;
			REG_HSTEP:  step_r = d[30:0];
			REG_TOL:    tol_r = d[15:0];
			REG_LIMIT:  limit_r = d[5:0];
			REG_MODE:   cn_r = d[0];
			default:    ;
		endcase
	endtask

	task automatic set_all(input logic [31:0] l, t, a, b, h, tl, lim, m);
		wait_drained();
		write_reg(REG_LAMBDA, l);
		write_reg(REG_THETA, t);
		write_reg(REG_ALPHA, a);
		write_reg(REG_BETA, b);
		write_reg(REG_HSTEP, h);
		write_reg(REG_TOL, tl);
		write_reg(REG_LIMIT, lim);
		write_reg(REG_MODE, m);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// near-unit values converge quickly; full-range values exercise saturation
	function automatic logic [31:0] tame_val();
		return 32'($urandom_range(0, 32'h3FF_FFFF)) - 32'h200_0000;
	endfunction

	task automatic queue_words(input int n, input int mix);
		in_word_t w;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < mix) begin
				w.u_in = $urandom;
				w.v_in = $urandom;
			end else begin
				w.u_in = tame_val();
				w.v_in = tame_val();
			end
			pending_words.push_back(w);
		end
	endtask

	task automatic queue_edges();
		logic [31:0] ev[6];
		in_word_t w;
		ev = '{WMAX, WMIN, 32'd0, ONE, -ONE, 32'h0033_3333};
		foreach (ev[p]) begin
			w.u_in = ev[p];
			w.v_in = ev[5 - p];
			pending_words.push_back(w);
		end
	endtask

	initial begin
		lam_r = 0; th_r = 0; alp_r = 0; bet_r = 0;
		step_r = 0; tol_r = 16; limit_r = 50; cn_r = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: zero step, guess already meets tolerance
		queue_edges();

		// well-behaved system, backward euler
		set_all(ONE, 32'h0033_3333, 32'h0080_0000, 32'h004C_CCCD, 32'h0019_999A,
			32'd16, 32'd50, 32'd0);
		queue_edges();
		queue_words(300, 5);

		// crank-nicolson with the same system
		set_all(ONE, 32'h0033_3333, 32'h0080_0000, 32'h004C_CCCD, 32'h0019_999A,
			32'd16, 32'd50, 32'd1);
		queue_edges();
		queue_words(300, 5);

		// singular jacobian: j11 = 0 and alpha = 0 make the determinant zero
		set_all(ONE, 32'h0033_3333, 32'd0, -ONE, ONE, 32'd16, 32'd3, 32'd0);
		queue_edges();
		queue_words(14, 50);

		// iteration limit of zero acts as one
		set_all(ONE, 32'h0033_3333, 32'h0080_0000, 32'h004C_CCCD, 32'h0080_0000,
			32'd0, 32'd0, 32'd0);
		queue_words(20, 20);

		// register extremes, full-range words
		set_all(WMAX, WMIN, WMIN, WMAX, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'd2, 32'd1);
		queue_edges();
		queue_words(200, 100);

		// longest limit, first with the largest tolerance and then with zero tolerance, only a few words
		set_all(32'h8000_0001, 32'h7FFF_FFFF, ONE, -ONE, 32'h7FFF_FFFF,
			32'h0000_FFFF, 32'd63, 32'd0);
		queue_words(3, 100);
		set_all(ONE, 32'd0, ONE, ONE, 32'h0100_0000, 32'd0, 32'd63, 32'd0);
		queue_words(3, 0);

		// random register settings, small limits keep the run short
		for (int ph = 0; ph < 6; ph++) begin
			set_all($urandom, $urandom, $urandom, $urandom, $urandom,
				{16'($urandom_range(0, 16'hFFFF)), 16'($urandom)},
				{26'($urandom), 6'($urandom_range(0, 4))}, $urandom);
			queue_words(150, 50);
		end

		// closing stretch with no idling on either side
		set_all(ONE, 32'h0033_3333, 32'h0080_0000, 32'h004C_CCCD, 32'h0019_999A,
			32'd16, 32'd8, 32'd1);
		quiet = 1'b1;
		queue_words(130, 10);

		wait_drained();
		repeat (50) @(posedge clk);
		if (fail_cnt == 0 && awaited_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire
